// ===== design/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants for the segment closest-point pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int CW   = 24;
  localparam int FB   = 12;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 2;
  localparam int WW   = 2 * SW;
  localparam int NW   = WW + 1;
  localparam int QW   = FB + 1;
  localparam int LTW  = 48;
  localparam int DTW  = 63;
  localparam int CFGW = 63;

  localparam logic [LTW-1:0] LEN_THR_RST = 48'd17;
  localparam logic [DTW-1:0] DEN_THR_RST = 63'd281474977;

  localparam logic REG_LEN_THR = 1'b0;
  localparam logic REG_DEN_THR = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [NW-1:0] wide_t;
  typedef logic [QW-1:0]        q_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } in_t;

  typedef struct packed {
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_a_z;
    coord_t near_b_x;
    coord_t near_b_y;
    coord_t near_b_z;
    q_t     param_a;
    q_t     param_b;
  } out_t;

  typedef struct packed {
    coord_t [2:0] sa;
    coord_t [2:0] sb;
    diff_t  [2:0] da;
    diff_t  [2:0] db;
  } geom_t;

  typedef struct packed {
    sum_t len_a;
    sum_t len_b;
    sum_t dot_a;
    sum_t dot_b;
    sum_t dab;
    logic pa;
    logic pb;
  } sums_t;

  typedef enum logic [2:0] {
    MODE_BOTH = 3'd0,
    MODE_T    = 3'd1,
    MODE_S0   = 3'd2,
    MODE_S1   = 3'd3,
    MODE_ST   = 3'd4
  } mode_t;

  typedef struct packed {
    geom_t g;
    sums_t m;
  } d1_side_t;

  typedef struct packed {
    geom_t g;
    q_t    s1;
    mode_t mode;
  } d2_side_t;

endpackage

// ===== design/ssc_mul.sv =====
// ----------------------------------------------------------------------------
// ssc_mul
// Two-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module ssc_mul
  #(
    parameter int AW = 52,
    parameter int BW = 52
  )
  (
    input  logic                  clk,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
  );

  localparam int AH = AW / 2;
  localparam int BH = BW / 2;
  localparam int MW = AW + BW;

  logic [AW-1:0] ua;
  logic [BW-1:0] ub;
  logic [AH+BH-1:0]           pll;
  logic [AH+BW-BH-1:0]        plh;
  logic [AW-AH+BH-1:0]        phl;
  logic [AW-AH+BW-BH-1:0]     phh;
  logic                       sgn;
  logic [MW-1:0]              mag;

  always_comb begin
    ua = a[AW-1] ? AW'(-a) : AW'(a);
    ub = b[BW-1] ? BW'(-b) : BW'(b);
  end

  always_ff @(posedge clk) begin
    pll <= ua[AH-1:0] * ub[BH-1:0];
    plh <= ua[AH-1:0] * ub[BW-1:BH];
    phl <= ua[AW-1:AH] * ub[BH-1:0];
    phh <= ua[AW-1:AH] * ub[BW-1:BH];
    sgn <= a[AW-1] ^ b[BW-1];
  end

  always_comb begin
    mag = (MW'(phh) << (AH + BH)) + (MW'(plh) << BH) + (MW'(phl) << AH) + MW'(pll);
  end

  always_ff @(posedge clk) begin
    p <= sgn ? $signed(-mag) : $signed(mag);
  end

endmodule

// ===== design/ssc_div.sv =====
// ----------------------------------------------------------------------------
// ssc_div
// Pipelined restoring divider, one quotient bit per stage, result clamped
// to [0, one].
// ----------------------------------------------------------------------------
module ssc_div
  #(
    parameter int W      = 16,
    parameter int QB     = 12,
    parameter int SIDE_W = 1
  )
  (
    input  logic                clk,
    input  logic                rst,
    input  logic                in_valid,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [QB:0]         quot,
    output logic [SIDE_W-1:0]   side_out
  );

  logic [QB:0]        v;
  logic [QB:0]        fz;
  logic [QB:0]        fo;
  logic [W-1:0]       rem  [QB+1];
  logic [W-1:0]       dn   [QB+1];
  logic [QB-1:0]      qq   [QB+1];
  logic [SIDE_W-1:0]  sd   [QB+1];
  logic [W+1:0]       trial [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[QB-1:0], in_valid};
    end
  end

  always_comb begin
    trial[0] = '0;
    for (int k = 1; k <= QB; k++) begin
      trial[k] = {1'b0, rem[k-1], 1'b0} - {2'b00, dn[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dn[0]  <= den;
    qq[0]  <= '0;
    sd[0]  <= side_in;
    fz[0]  <= num[W-1] | (num == '0);
    fo[0]  <= !num[W-1] && (num >= den);
    for (int k = 1; k <= QB; k++) begin
      dn[k] <= dn[k-1];
      sd[k] <= sd[k-1];
      fz[k] <= fz[k-1];
      fo[k] <= fo[k-1];
      if (!trial[k][W+1]) begin
        rem[k] <= trial[k][W-1:0];
        qq[k]  <= {qq[k-1][QB-2:0], 1'b1};
      end else begin
        rem[k] <= {rem[k-1][W-2:0], 1'b0};
        qq[k]  <= {qq[k-1][QB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    out_valid = v[QB];
    side_out  = sd[QB];
    if (fz[QB]) begin
      quot = '0;
    end else if (fo[QB]) begin
      quot = (QB+1)'(1) << QB;
    end else begin
      quot = {1'b0, qq[QB]};
    end
  end

endmodule

// ===== design/segment_segment_closest_points.sv =====
// ----------------------------------------------------------------------------
// segment_segment_closest_points
// Closest points between two 3D segments, fully pipelined.
// Throughput: one segment pair per cycle; every stage, including both
// 13-stage dividers, takes a new item each cycle and the receiver cannot stall.
// Reset: synchronous; clears valid bits and loads threshold defaults, busy
// is high while rst is high.
// ----------------------------------------------------------------------------
module segment_segment_closest_points
  import ssc_pkg::*;
  (
    input  logic            clk,
    input  logic            rst,
    input  logic            start,
    output logic            busy,
    input  in_t             data,
    output logic            done,
    output out_t            result,
    input  logic            wr_en,
    input  logic            wr_index,
    input  logic [CFGW-1:0] wr_data
  );

  localparam int LPW = DW + QW + 1;
  localparam logic signed [LPW-1:0] HALF = LPW'(1) << (FB - 1);
  localparam q_t ONE = QW'(1) << FB;

  logic [LTW-1:0] len_thr;
  logic [DTW-1:0] den_thr;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      len_thr <= LEN_THR_RST;
      den_thr <= DEN_THR_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEN_THR: len_thr <= wr_data[LTW-1:0];
        REG_DEN_THR: den_thr <= wr_data[DTW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic v0, v1, v2, v3, v4, v5, v6, v7, v9, v10, v12;
  logic v8, v11;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6, v7, v9, v10, v12, done} <= '0;
    end else begin
      v0   <= start & !busy;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v9   <= v8;
      v10  <= v9;
      v12  <= v11;
      done <= v12;
    end
  end

  // input register
  in_t in_reg;
  always_ff @(posedge clk) begin
    in_reg <= data;
  end

  // differences
  geom_t g1;
  diff_t [2:0] r1;
  coord_t [2:0] as_c, ae_c, bs_c, be_c;
  always_comb begin
    as_c = {in_reg.a_start_z, in_reg.a_start_y, in_reg.a_start_x};
    ae_c = {in_reg.a_end_z, in_reg.a_end_y, in_reg.a_end_x};
    bs_c = {in_reg.b_start_z, in_reg.b_start_y, in_reg.b_start_x};
    be_c = {in_reg.b_end_z, in_reg.b_end_y, in_reg.b_end_x};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      g1.sa[i] <= as_c[i];
      g1.sb[i] <= bs_c[i];
      g1.da[i] <= DW'($signed(ae_c[i])) - DW'($signed(as_c[i]));
      g1.db[i] <= DW'($signed(be_c[i])) - DW'($signed(bs_c[i]));
      r1[i]    <= DW'($signed(as_c[i])) - DW'($signed(bs_c[i]));
    end
  end

  // products
  geom_t g2;
  logic signed [PW-1:0] paa [3];
  logic signed [PW-1:0] pbb [3];
  logic signed [PW-1:0] par [3];
  logic signed [PW-1:0] pbr [3];
  logic signed [PW-1:0] pab [3];
  always_ff @(posedge clk) begin
    g2 <= g1;
    for (int i = 0; i < 3; i++) begin
      paa[i] <= $signed(g1.da[i]) * $signed(g1.da[i]);
      pbb[i] <= $signed(g1.db[i]) * $signed(g1.db[i]);
      par[i] <= $signed(g1.da[i]) * $signed(r1[i]);
      pbr[i] <= $signed(g1.db[i]) * $signed(r1[i]);
      pab[i] <= $signed(g1.da[i]) * $signed(g1.db[i]);
    end
  end

  // dot products
  geom_t g3;
  sums_t sm3;
  always_ff @(posedge clk) begin
    g3        <= g2;
    sm3.len_a <= SW'(paa[0]) + SW'(paa[1]) + SW'(paa[2]);
    sm3.len_b <= SW'(pbb[0]) + SW'(pbb[1]) + SW'(pbb[2]);
    sm3.dot_a <= SW'(par[0]) + SW'(par[1]) + SW'(par[2]);
    sm3.dot_b <= SW'(pbr[0]) + SW'(pbr[1]) + SW'(pbr[2]);
    sm3.dab   <= SW'(pab[0]) + SW'(pab[1]) + SW'(pab[2]);
    sm3.pa    <= 1'b0;
    sm3.pb    <= 1'b0;
  end

  // degenerate tests, wide products start
  geom_t g4, g5;
  sums_t sm3t, sm4, sm5;
  logic signed [WW-1:0] m_ab, m_dd, m_db, m_al;

  ssc_mul #(.AW(SW), .BW(SW)) u_mul_ab (.clk(clk), .a(sm3.len_a), .b(sm3.len_b), .p(m_ab));
  ssc_mul #(.AW(SW), .BW(SW)) u_mul_dd (.clk(clk), .a(sm3.dab),   .b(sm3.dab),   .p(m_dd));
  ssc_mul #(.AW(SW), .BW(SW)) u_mul_db (.clk(clk), .a(sm3.dab),   .b(sm3.dot_b), .p(m_db));
  ssc_mul #(.AW(SW), .BW(SW)) u_mul_al (.clk(clk), .a(sm3.dot_a), .b(sm3.len_b), .p(m_al));

  always_comb begin
    sm3t    = sm3;
    sm3t.pa = sm3.len_a <= $signed(SW'(len_thr));
    sm3t.pb = sm3.len_b <= $signed(SW'(len_thr));
  end

  always_ff @(posedge clk) begin
    g4     <= g3;
    sm4    <= sm3t;
    g5     <= g4;
    sm5    <= sm4;
  end

  // system denominator and s numerator
  geom_t g6, g7;
  sums_t sm6, sm7;
  wide_t den6, snum6, num7, den7;
  wide_t dpos, dneg;
  always_comb begin
    dpos = NW'(m_ab) - NW'(m_dd);
    dneg = NW'(m_dd) - NW'(m_ab);
  end

  always_ff @(posedge clk) begin
    g6    <= g5;
    sm6   <= sm5;
    den6  <= dpos[NW-1] ? dneg : dpos;
    snum6 <= NW'(m_db) - NW'(m_al);
    g7    <= g6;
    sm7   <= sm6;
    den7  <= den6;
    num7  <= ($unsigned(den6) > NW'(den_thr)) ? snum6 : '0;
  end

  // first divider: s from the 2x2 system
  d1_side_t d1_in, d1_out;
  logic [$bits(d1_side_t)-1:0] d1_out_vec;
  q_t s1;
  always_comb begin
    d1_in.g = g7;
    d1_in.m = sm7;
  end

  ssc_div #(.W(NW), .QB(FB), .SIDE_W($bits(d1_side_t))) u_div_s (
    .clk(clk), .rst(rst), .in_valid(v7), .num(num7), .den(den7),
    .side_in(d1_in), .out_valid(v8), .quot(s1), .side_out(d1_out_vec)
  );

  assign d1_out = d1_side_t'(d1_out_vec);

  // t numerator
  geom_t g9, g10;
  sums_t sm9;
  q_t s1_9, s1_10;
  wide_t tnum9, tden9;
  logic signed [SW+QW:0] dab_s;
  always_comb begin
    dab_s = $signed(d1_out.m.dab) * $signed({1'b0, s1});
  end

  always_ff @(posedge clk) begin
    g9    <= d1_out.g;
    sm9   <= d1_out.m;
    s1_9  <= s1;
    tnum9 <= NW'(dab_s) + (NW'(d1_out.m.dot_b) <<< FB);
    tden9 <= NW'(d1_out.m.len_b) <<< FB;
  end

  // case selection for the second divider
  wide_t num10, den10;
  mode_t mode10;
  wide_t neg_dot_a, dab_m_dot_a;
  always_comb begin
    neg_dot_a   = -NW'(sm9.dot_a);
    dab_m_dot_a = NW'(sm9.dab) - NW'(sm9.dot_a);
  end

  always_ff @(posedge clk) begin
    g10   <= g9;
    s1_10 <= s1_9;
    case ({sm9.pa, sm9.pb})
      2'b11: begin
        mode10 <= MODE_BOTH;
        num10  <= '0;
        den10  <= NW'(1);
      end
      2'b10: begin
        mode10 <= MODE_T;
        num10  <= NW'(sm9.dot_b);
        den10  <= NW'(sm9.len_b);
      end
      2'b01: begin
        mode10 <= MODE_S0;
        num10  <= neg_dot_a;
        den10  <= NW'(sm9.len_a);
      end
      default: begin
        if (tnum9[NW-1]) begin
          mode10 <= MODE_S0;
          num10  <= neg_dot_a;
          den10  <= NW'(sm9.len_a);
        end else if (tnum9 > tden9) begin
          mode10 <= MODE_S1;
          num10  <= dab_m_dot_a;
          den10  <= NW'(sm9.len_a);
        end else begin
          mode10 <= MODE_ST;
          num10  <= tnum9;
          den10  <= tden9;
        end
      end
    endcase
  end

  // second divider: the remaining parameter
  d2_side_t d2_in, d2_out;
  logic [$bits(d2_side_t)-1:0] d2_out_vec;
  q_t q2;
  always_comb begin
    d2_in.g    = g10;
    d2_in.s1   = s1_10;
    d2_in.mode = mode10;
  end

  ssc_div #(.W(NW), .QB(FB), .SIDE_W($bits(d2_side_t))) u_div_t (
    .clk(clk), .rst(rst), .in_valid(v10), .num(num10), .den(den10),
    .side_in(d2_in), .out_valid(v11), .quot(q2), .side_out(d2_out_vec)
  );

  assign d2_out = d2_side_t'(d2_out_vec);

  // final parameters and offsets
  q_t s11, t11, s12, t12;
  logic signed [LPW-1:0] offa [3];
  logic signed [LPW-1:0] offb [3];
  coord_t [2:0] sa12, sb12;
  always_comb begin
    case (d2_out.mode)
      MODE_BOTH: begin s11 = '0;        t11 = '0;  end
      MODE_T:    begin s11 = '0;        t11 = q2;  end
      MODE_S0:   begin s11 = q2;        t11 = '0;  end
      MODE_S1:   begin s11 = q2;        t11 = ONE; end
      MODE_ST:   begin s11 = d2_out.s1; t11 = q2;  end
      default:   begin s11 = '0;        t11 = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    s12  <= s11;
    t12  <= t11;
    sa12 <= d2_out.g.sa;
    sb12 <= d2_out.g.sb;
    for (int i = 0; i < 3; i++) begin
      offa[i] <= $signed(d2_out.g.da[i]) * $signed({1'b0, s11});
      offb[i] <= $signed(d2_out.g.db[i]) * $signed({1'b0, t11});
    end
  end

  // rounding and output register
  coord_t [2:0] na, nb;
  logic signed [LPW-1:0] ra, rb;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra    = (offa[i] + HALF) >>> FB;
      rb    = (offb[i] + HALF) >>> FB;
      na[i] = sa12[i] + CW'(ra);
      nb[i] = sb12[i] + CW'(rb);
    end
  end

  always_ff @(posedge clk) begin
    result.near_a_x <= na[0];
    result.near_a_y <= na[1];
    result.near_a_z <= na[2];
    result.near_b_x <= nb[0];
    result.near_b_y <= nb[1];
    result.near_b_z <= nb[2];
    result.param_a  <= s12;
    result.param_b  <= t12;
  end

endmodule

// ===== test/tb_segment_segment_closest_points.sv =====
// ----------------------------------------------------------------------------
// tb_segment_segment_closest_points
// Self-checking bench for the segment closest-point pipeline: a scoreboard
// predicts each transfer with wide integer arithmetic and checks every result
// in order, across several threshold settings, directed and random pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_segment_closest_points;
  import ssc_pkg::*;

  typedef logic signed [191:0] acc_t;
  localparam int ONE_Q    = 1 << FB;
  localparam int SETTLE   = 60;
  localparam int LIMIT    = 400000;
  localparam int PER_PASS = 380;

  class closest_scoreboard;
    acc_t   len_thr;
    acc_t   den_thr;
    out_t   pending[$];
    int     errors;
    int     checked;

    function new();
      len_thr = acc_t'(LEN_THR_RST);
      den_thr = acc_t'(DEN_THR_RST);
      errors  = 0;
      checked = 0;
    endfunction

    function int quot(acc_t num, acc_t den);
      int q;
      q = 0;
      if (num <= 0) return 0;
      if (num >= den) return ONE_Q;
      for (int i = 0; i < FB; i++) begin
        num = num <<< 1;
        q = q << 1;
        if (num >= den) begin
          num = num - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    function coord_t lerp(acc_t st, acc_t seg, int p);
      acc_t v;
      v = seg * acc_t'(p) + acc_t'(ONE_Q / 2);
      v = st + (v >>> FB);
      return v[CW-1:0];
    endfunction

    function out_t predict(in_t x);
      acc_t sa[3], sb[3], da[3], db[3], r[3];
      acc_t len_a, len_b, dot_a, dot_b, dab, den, tnum, tden;
      int   s, t;
      out_t o;
      sa[0] = x.a_start_x; sa[1] = x.a_start_y; sa[2] = x.a_start_z;
      sb[0] = x.b_start_x; sb[1] = x.b_start_y; sb[2] = x.b_start_z;
      da[0] = acc_t'(x.a_end_x) - sa[0];
      da[1] = acc_t'(x.a_end_y) - sa[1];
      da[2] = acc_t'(x.a_end_z) - sa[2];
      db[0] = acc_t'(x.b_end_x) - sb[0];
      db[1] = acc_t'(x.b_end_y) - sb[1];
      db[2] = acc_t'(x.b_end_z) - sb[2];
      len_a = 0; len_b = 0; dot_a = 0; dot_b = 0; dab = 0;
      for (int i = 0; i < 3; i++) begin
        r[i]  = sa[i] - sb[i];
        len_a = len_a + da[i] * da[i];
        len_b = len_b + db[i] * db[i];
        dot_a = dot_a + da[i] * r[i];
        dot_b = dot_b + db[i] * r[i];
        dab   = dab + da[i] * db[i];
      end
      s = 0;
      t = 0;
      if (len_a <= len_thr && len_b <= len_thr) begin
        // both points
      end else if (len_a <= len_thr) begin
        t = quot(dot_b, len_b);
      end else if (len_b <= len_thr) begin
        s = quot(-dot_a, len_a);
      end else begin
        den = len_a * len_b - dab * dab;
        if (den < 0) den = -den;
        if (den > den_thr) s = quot(dab * dot_b - dot_a * len_b, den);
        tnum = dab * acc_t'(s) + dot_b * acc_t'(ONE_Q);
        tden = len_b * acc_t'(ONE_Q);
        if (tnum < 0) begin
          t = 0;
          s = quot(-dot_a, len_a);
        end else if (tnum > tden) begin
          t = ONE_Q;
          s = quot(dab - dot_a, len_a);
        end else begin
          t = quot(tnum, tden);
        end
      end
      o.near_a_x = lerp(sa[0], da[0], s);
      o.near_a_y = lerp(sa[1], da[1], s);
      o.near_a_z = lerp(sa[2], da[2], s);
      o.near_b_x = lerp(sb[0], db[0], t);
      o.near_b_y = lerp(sb[1], db[1], t);
      o.near_b_z = lerp(sb[2], db[2], t);
      o.param_a  = q_t'(s);
      o.param_b  = q_t'(t);
      return o;
    endfunction

    function void note(in_t x);
      pending.push_back(predict(x));
    endfunction

    function void cmp(string name, logic [CW-1:0] e, logic [CW-1:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check(out_t a);
      out_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("near_a_x", e.near_a_x, a.near_a_x);
      cmp("near_a_y", e.near_a_y, a.near_a_y);
      cmp("near_a_z", e.near_a_z, a.near_a_z);
      cmp("near_b_x", e.near_b_x, a.near_b_x);
      cmp("near_b_y", e.near_b_y, a.near_b_y);
      cmp("near_b_z", e.near_b_z, a.near_b_z);
      cmp("param_a", CW'(e.param_a), CW'(a.param_a));
      cmp("param_b", CW'(e.param_b), CW'(a.param_b));
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  in_t             data = '0;
  logic            done;
  out_t            result;
  logic            wr_en = 1'b0;
  logic            wr_index = REG_LEN_THR;
  logic [CFGW-1:0] wr_data = '0;

  closest_scoreboard sb = new();
  int unsigned cycles = 0;
  int          sent = 0;

  segment_segment_closest_points dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .data(data),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_segment_segment_closest_points: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note(data);
      if (done) sb.check(result);
    end
  end

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFGW-1:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    wr_en    <= 1'b0;
    @(posedge clk);
    if (idx == REG_LEN_THR) sb.len_thr = acc_t'(v[LTW-1:0]);
    else sb.den_thr = acc_t'(v[DTW-1:0]);
  endtask

  // start stays high across back-to-back transfers
  task automatic send(in_t x, bit gaps);
    data  <= x;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic coord_t rnd_small();
    return coord_t'(int'($urandom_range(0, 16383)) - 8192);
  endfunction

  function automatic in_t gen();
    in_t x;
    int  k;
    x = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1: begin
      end
      2, 3, 4: begin
        x.a_start_x = rnd_small(); x.a_start_y = rnd_small(); x.a_start_z = rnd_small();
        x.a_end_x = rnd_small(); x.a_end_y = rnd_small(); x.a_end_z = rnd_small();
        x.b_start_x = rnd_small(); x.b_start_y = rnd_small(); x.b_start_z = rnd_small();
        x.b_end_x = rnd_small(); x.b_end_y = rnd_small(); x.b_end_z = rnd_small();
      end
      5: begin
        x.a_end_x = x.a_start_x + coord_t'(int'($urandom_range(0, 2)) - 1);
        x.a_end_y = x.a_start_y; x.a_end_z = x.a_start_z;
      end
      6: begin
        x.b_end_x = x.b_start_x; x.b_end_y = x.b_start_y + coord_t'($urandom_range(0, 4));
        x.b_end_z = x.b_start_z;
      end
      7: begin
        x.a_end_x = x.a_start_x; x.a_end_y = x.a_start_y; x.a_end_z = x.a_start_z;
        x.b_end_x = x.b_start_x; x.b_end_y = x.b_start_y; x.b_end_z = x.b_start_z;
      end
      default: begin
        k = $urandom_range(1, 2);
        x.a_start_x = rnd_small(); x.a_start_y = rnd_small(); x.a_start_z = rnd_small();
        x.a_end_x = rnd_small(); x.a_end_y = rnd_small(); x.a_end_z = rnd_small();
        x.b_start_x = rnd_small(); x.b_start_y = rnd_small(); x.b_start_z = rnd_small();
        x.b_end_x = x.b_start_x + coord_t'(k) * (x.a_end_x - x.a_start_x);
        x.b_end_y = x.b_start_y + coord_t'(k) * (x.a_end_y - x.a_start_y);
        x.b_end_z = x.b_start_z + coord_t'(k) * (x.a_end_z - x.a_start_z);
      end
    endcase
    return x;
  endfunction

  function automatic in_t seg(int ax, int ay, int az, int bx, int by, int bz,
                              int cx, int cy, int cz, int dx, int dy, int dz);
    return '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
             coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(dx),
             coord_t'(dy), coord_t'(dz)};
  endfunction

  initial begin
    logic [CFGW-1:0] lens[5];
    logic [CFGW-1:0] dens[5];
    in_t  maxv, minv;
    lens = '{63'd0, {15'd0, {LTW{1'b1}}}, 63'd17, 63'd0, 63'd17};
    dens = '{63'd0, {DTW{1'b1}}, 63'd281474977, 63'd0, 63'd281474977};
    maxv = '{default: coord_t'(8388607)};
    minv = '{default: coord_t'(-8388608)};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs with reset thresholds
    send('0, 0);
    send(maxv, 0);
    send(minv, 0);
    send(seg(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
             8388607, -8388608, 8388607, -8388608, 8388607, -8388608), 0);
    send(seg(0, 0, 0, 0, 0, 0, 4096, 4096, 0, -4096, 4096, 0), 0);
    send(seg(0, 0, 0, 4096, 0, 0, 8192, 4096, 0, 8192, 4096, 0), 0);
    send(seg(0, 0, 0, 8192, 0, 0, 4096, -4096, 4096, 4096, 4096, 4096), 1);
    send(seg(0, 0, 0, 8192, 0, 0, 0, 4096, 0, 8192, 4096, 0), 0);
    send(seg(0, 0, 0, 4096, 0, 0, -8192, 100, 0, -16384, 900, 0), 1);
    send(seg(0, 0, 0, 4096, 0, 0, 12288, 100, 0, 20480, 900, 0), 0);
    send(seg(0, 0, 0, 4096, 0, 0, -4096, 4096, 0, -4096, 8192, 0), 0);
    send(seg(0, 0, 0, 4096, 0, 0, 8192, 4096, 0, 8192, 8192, 0), 1);
    send(seg(0, 0, 0, 4, 0, 0, 100, 100, 100, 102, 101, 100), 0);
    send(seg(1000, -2000, 3000, 1000, -2000, 3000, 0, 0, 0, 5000, 5000, 5000), 0);
    send(seg(-8388608, 0, 0, 8388607, 0, 0, 0, 8388607, 0, 0, -8388608, 0), 0);
    send(seg(0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 1, 2), 0);
    start <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      if (ph == 3) begin
        lens[3] = 63'($urandom_range(0, 1 << 20));
        dens[3] = CFGW'({$urandom, $urandom} & {DTW{1'b1}} >> $urandom_range(8, 40));
      end
      write_reg(REG_LEN_THR, lens[ph]);
      write_reg(REG_DEN_THR, dens[ph]);
      for (int i = 0; i < PER_PASS; i++) begin
        send(gen(), ph < 4);
        if (ph == 2 && i == PER_PASS / 2) begin
          start <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
    end

    drain();
    $display("sent %0d segment pairs over five threshold settings, checked %0d results",
             sent, sb.checked);
    $display("covered point, parallel, clamped and general segment pairs");
    if (sb.errors == 0) begin
      $display("tb_segment_segment_closest_points: done, clean");
    end else begin
      $display("tb_segment_segment_closest_points: done, errors");
    end
    $finish;
  end

endmodule
